### hw/rtl/dentsort_pkg.sv
package dentsort_pkg;

   localparam int WORD_BITS = 64;
   localparam int WORD_BYTES = 8;
   localparam int POS_W = 6;

   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_SORT = 1'b1
   } cmd_type;

   // result of comparing one 8-byte slice of two names
   typedef struct packed {
      logic decided;   // a differing byte or a terminating zero was found
      logic after;     // name a sorts after name b
   } cmp_result_type;

endpackage

### hw/rtl/dentsort_cmp_unit.sv
module dentsort_cmp_unit (
   input  logic [dentsort_pkg::WORD_BITS-1:0] word_a,
   input  logic [dentsort_pkg::WORD_BITS-1:0] word_b,
   output dentsort_pkg::cmp_result_type       result
);

   // byte 0 sits in the top bits; first differing or zero byte decides
   always_comb begin
      logic [7:0] xa;
      logic [7:0] xb;
      result = '0;
      for (int k = 0; k < dentsort_pkg::WORD_BYTES; k++) begin
         xa = word_a[dentsort_pkg::WORD_BITS-1-8*k -: 8];
         xb = word_b[dentsort_pkg::WORD_BITS-1-8*k -: 8];
         if (!result.decided) begin
            if (xa != xb) begin
               result.decided = 1'b1;
               result.after = (xa > xb);
            end else if (xa == 8'd0) begin
               result.decided = 1'b1;
               result.after = 1'b0;
            end
         end
      end
   end

endmodule

### hw/rtl/dentsort_name_ram.sv
module dentsort_name_ram #(
   parameter int DEPTH = 128,
   parameter int AW = 7
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [AW-1:0]                       wr_addr,
   input  logic [dentsort_pkg::WORD_BITS-1:0]  wr_data,
   input  logic [AW-1:0]                       rd_addr_a,
   input  logic [AW-1:0]                       rd_addr_b,
   output logic [dentsort_pkg::WORD_BITS-1:0]  rd_data_a,
   output logic [dentsort_pkg::WORD_BITS-1:0]  rd_data_b
);

   logic [dentsort_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [dentsort_pkg::WORD_BITS-1:0] rd_a_ff;
   logic [dentsort_pkg::WORD_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### hw/rtl/directory_entry_sorter_top.sv
// Directory entry sorter.
// Input channel (req_*): one transaction per name chunk (req_cmd = load) or one
// sort command (req_cmd = sort). A name is NAME_BYTES/8 chunks; the chunk with
// the last index completes the entry and carries req_is_directory. Loads past
// MAX_ENTRIES are dropped. A load gives no result.
// Sort: stable gnome sort, directories first, then unsigned byte-wise names.
// Each compare step reads both names through a two-port name RAM and a
// single compare unit that checks all eight bytes of a chunk: it fetches the
// order pair (S_RDO), then reads (S_RDN) and compares (S_CMP) chunk by chunk
// until the pair is decided, plus S_SWB per swap. Gnome sort needs up to n*n steps.
// Result channel (rsp_*): one transaction per sorted entry (S_EMRD, S_EMO,
// S_WAIT, held by any receiver stall); the input is not ready from the sort
// command until the last result (rsp_last_in_run) is taken. An empty list gives
// one result with rsp_entry_valid low. After the run the entry count is zero.
// Reset clears the entry count and the control state; name and order stores
// are not cleared. A stalled receiver simply holds the result register.
module directory_entry_sorter_top #(
   parameter int MAX_ENTRIES = 64,
   parameter int NAME_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [63:0] req_name_chunk,
   input  logic        req_chunk_index,
   input  logic        req_is_directory,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_entry_valid,
   output logic [5:0]  rsp_entry_position,
   output logic        rsp_entry_is_dir,
   output logic        rsp_last_in_run
);

   localparam int CHUNKS = NAME_BYTES / 8;
   localparam logic LAST_CHUNK = (CHUNKS > 1);
   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int DEPTH = MAX_ENTRIES * CHUNKS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CHW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_RDO  = 8'b0000_0010,  // read order pair
      S_RDN  = 8'b0000_0100,  // read name chunk pair
      S_CMP  = 8'b0000_1000,  // compare chunk, decide
      S_SWB  = 8'b0001_0000,  // second swap write
      S_EMRD = 8'b0010_0000,  // read order entry for output
      S_EMO  = 8'b0100_0000,  // load result register
      S_WAIT = 8'b1000_0000   // result waits for receiver
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [IW-1:0]   emit_ff, emit_in;
   logic [CHW-1:0]  chunk_ff, chunk_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_ev_ff, rsp_ev_in;
   logic [5:0]      rsp_pos_ff, rsp_pos_in;
   logic            rsp_dir_ff, rsp_dir_in;
   logic            rsp_last_ff, rsp_last_in;

   // order store: {dir flag, load index}, written at load time in load order
   logic [IW:0]     order_mem [MAX_ENTRIES];
   logic [IW:0]     ord_a_ff, ord_b_ff;
   logic            ord_we;
   logic [IW-1:0]   ord_waddr;
   logic [IW:0]     ord_wdata;
   logic [IW-1:0]   ord_raddr_a;
   logic [IW-1:0]   ord_raddr_b;

   logic            nm_we;
   logic [AW-1:0]   nm_waddr;
   logic [AW-1:0]   nm_raddr_a, nm_raddr_b;
   logic [63:0]     nm_a, nm_b;
   dentsort_pkg::cmp_result_type cmp;

   logic            load_ok;
   logic            load_last;
   logic [IW-1:0]   idx_next;

   assign load_ok = req_valid && (state_ff == S_IDLE)
                    && (req_cmd == dentsort_pkg::CMD_LOAD)
                    && (count_ff < CW'(MAX_ENTRIES))
                    && ((CHUNKS > 1) || (req_chunk_index == 1'b0));
   assign load_last = (req_chunk_index == LAST_CHUNK);
   assign idx_next = idx_ff + IW'(1);

   assign nm_we = load_ok;
   assign nm_waddr = AW'(count_ff) * AW'(CHUNKS) + AW'(req_chunk_index);
   assign nm_raddr_a = AW'(ord_a_ff[IW-1:0]) * AW'(CHUNKS) + AW'(chunk_ff);
   assign nm_raddr_b = AW'(ord_b_ff[IW-1:0]) * AW'(CHUNKS) + AW'(chunk_ff);

   dentsort_name_ram #(.DEPTH(DEPTH), .AW(AW)) u_name_ram (
      .clock     (clock),
      .wr_en     (nm_we),
      .wr_addr   (nm_waddr),
      .wr_data   (req_name_chunk),
      .rd_addr_a (nm_raddr_a),
      .rd_addr_b (nm_raddr_b),
      .rd_data_a (nm_a),
      .rd_data_b (nm_b)
   );

   dentsort_cmp_unit u_cmp (
      .word_a (nm_a),
      .word_b (nm_b),
      .result (cmp)
   );

   // order store write port: load, first and second half of a swap
   always_comb begin
      ord_we = 1'b0;
      ord_waddr = count_ff[IW-1:0];
      ord_wdata = {req_is_directory, count_ff[IW-1:0]};
      if (load_ok && load_last) begin
         ord_we = 1'b1;
      end else if (state_ff == S_SWB) begin
         ord_we = 1'b1;
         ord_waddr = idx_next;
         ord_wdata = ord_a_ff;
      end else if (state_in == S_SWB) begin
         ord_we = 1'b1;
         ord_waddr = idx_ff;
         ord_wdata = ord_b_ff;
      end
   end

   assign ord_raddr_a = (state_ff == S_EMRD) ? emit_ff : idx_ff;
   assign ord_raddr_b = idx_next;

   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_waddr] <= ord_wdata;
      end
      ord_a_ff <= order_mem[ord_raddr_a];
      ord_b_ff <= order_mem[ord_raddr_b];
   end

   // sequencer
   always_comb begin
      logic do_swap;
      logic done;
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      emit_in = emit_ff;
      chunk_in = chunk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ev_in = rsp_ev_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_dir_in = rsp_dir_ff;
      rsp_last_in = rsp_last_ff;
      do_swap = 1'b0;
      done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == dentsort_pkg::CMD_LOAD) begin
                  if (load_ok && load_last) begin
                     count_in = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_ev_in = 1'b0;
                  rsp_pos_in = '0;
                  rsp_dir_in = 1'b0;
                  rsp_last_in = 1'b1;
                  state_in = S_WAIT;
               end else if (count_ff == CW'(1)) begin
                  emit_in = '0;
                  state_in = S_EMRD;
               end else begin
                  idx_in = '0;
                  state_in = S_RDO;
               end
            end
         end
         S_RDO: begin
            chunk_in = '0;
            state_in = S_RDN;
         end
         S_RDN: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ord_a_ff[IW] != ord_b_ff[IW]) begin
               done = 1'b1;
               do_swap = ord_b_ff[IW];
            end else if (cmp.decided) begin
               done = 1'b1;
               do_swap = cmp.after;
            end else if (chunk_ff == CHW'(CHUNKS - 1)) begin
               done = 1'b1;
            end else begin
               chunk_in = chunk_ff + CHW'(1);
               state_in = S_RDN;
            end
            if (done) begin
               if (do_swap) begin
                  state_in = S_SWB;
               end else if (CW'(idx_next) + CW'(1) < count_ff) begin
                  idx_in = idx_next;
                  state_in = S_RDO;
               end else begin
                  emit_in = '0;
                  state_in = S_EMRD;
               end
            end
         end
         S_SWB: begin
            if (idx_ff != '0) begin
               idx_in = idx_ff - IW'(1);
            end
            state_in = S_RDO;
         end
         S_EMRD: begin
            state_in = S_EMO;
         end
         S_EMO: begin
            rsp_valid_in = 1'b1;
            rsp_ev_in = 1'b1;
            rsp_pos_in = 6'(ord_a_ff[IW-1:0]);
            rsp_dir_in = ord_a_ff[IW];
            rsp_last_in = (CW'(emit_ff) + CW'(1) == count_ff);
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  emit_in = emit_ff + IW'(1);
                  state_in = S_EMRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      emit_ff <= emit_in;
      chunk_ff <= chunk_in;
      rsp_ev_ff <= rsp_ev_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_dir_ff <= rsp_dir_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry_valid = rsp_ev_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_entry_is_dir = rsp_dir_ff;
   assign rsp_last_in_run = rsp_last_ff;

   // a result only waits in the output state, never while input is open
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result pending while input ready");

   // compare step always works on a pair inside the loaded list
   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (CW'(idx_ff) + CW'(1) < count_ff))
      else $error("compare index out of range");

   // final result of a run empties the list
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_in_run) |=> (count_ff == '0))
      else $error("entry count not cleared after run");

   // full store ignores further loads
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == dentsort_pkg::CMD_LOAD)
       && (count_ff == CW'(MAX_ENTRIES))) |=> (count_ff == CW'(MAX_ENTRIES)))
      else $error("load accepted past capacity");

endmodule
